// File: rtl/hrrn_job_dispatcher_assert.svh
// ----------------------------------------------------------------------------
// HRRN dispatcher assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef HRRN_JOB_DISPATCHER_ASSERT_SVH
`define HRRN_JOB_DISPATCHER_ASSERT_SVH

`ifndef SYNTHESIS
`define HRRN_CHK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrrn check failed");
`define HRRN_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrrn next-cycle check failed");
`else
`define HRRN_CHK(lbl, ante, cons)
`define HRRN_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/hrrn_pkg.sv
// ----------------------------------------------------------------------------
// HRRN dispatcher package
// Field widths, action codes, sequencer states and divider status type.
// ----------------------------------------------------------------------------
package hrrn_pkg;

  localparam int TIME_W     = 32;
  localparam int ID_IN_W    = 10;
  localparam int BURST_IN_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = 4;
  localparam int NUM_W      = 33;

  localparam logic ACT_ARRIVAL = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_LATCH,
    ST_DIVGO,
    ST_DIV,
    ST_PICK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_REPORT
  } hrrn_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// File: rtl/hrrn_ram.sv
// ----------------------------------------------------------------------------
// HRRN generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hrrn_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/hrrn_div.sv
// ----------------------------------------------------------------------------
// HRRN serial divider
// Restoring division, one quotient bit per cycle, shared by all ratio checks.
// ----------------------------------------------------------------------------
module hrrn_div import hrrn_pkg::*; #(
  parameter int N_W = 33,
  parameter int D_W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output div_rsp_t       rsp,
  output logic [N_W-1:0] quo
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0]   qn_r, qn_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   den_r, den_nxt;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             ge;

  assign trial = {rem_r, qn_r[N_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    qn_nxt   = qn_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(N_W);
      qn_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      qn_nxt  = {qn_r[N_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qn_r  <= qn_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign quo      = qn_r;

endmodule

// File: rtl/hrrn_job_dispatcher.sv
// ----------------------------------------------------------------------------
// HRRN job dispatcher
// Non-preemptive highest-response-ratio-next dispatcher with a wait queue.
// ----------------------------------------------------------------------------
// Input requests come on in_*; in_tuser selects arrival (0) or tick (1).
// An arrival queues job_id and burst_len stamped with the current slot;
// with the queue full it is dropped and a sticky flag set.
// A tick releases a finished job, and if the machine is free it scans the
// queue, computing (now - stamp + burst) / burst for each waiting job in one
// shared serial divider, picks the largest (earliest on a tie), then closes
// the gap in the queue one entry at a time, each read and then written back
// one place up. For each job the scan reads the entry, latches it and runs
// the divider. in_tready is low while a tick is in work. Each tick gives one
// report on out_* held in an output register; the next arrival is taken
// while a report waits, and a tick that finishes while out_tready is low
// holds until the report drains.
// Reset clears time, the machine state, the queue count and the drop flag;
// the queue memory needs no clearing.
// ----------------------------------------------------------------------------
`include "hrrn_job_dispatcher_assert.svh"

module hrrn_job_dispatcher import hrrn_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 10,
  parameter int BURST_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // job_id[9:0], burst_len[25:10], zero pad
  input  logic                  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // slot_time[31:0], busy_res[32],
                                            // running_id[42:33], dropped[43], zero pad
);

  localparam int IDW     = (ID_BITS < ID_IN_W) ? ID_BITS : ID_IN_W;
  localparam int BW      = (BURST_BITS < BURST_IN_W) ? BURST_BITS : BURST_IN_W;
  localparam int AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = IDW + TIME_W + BW;

  hrrn_state_t           state_r, state_nxt;
  logic [TIME_W-1:0]     time_r, time_nxt;
  logic                  busy_r, busy_nxt;
  logic [IDW-1:0]        cur_r, cur_nxt;
  logic [TIME_W-1:0]     fin_r, fin_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  drop_r, drop_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         best_idx_r, best_idx_nxt;
  logic [NUM_W-1:0]      best_q_r, best_q_nxt;
  logic [IDW-1:0]        best_id_r, best_id_nxt;
  logic [BW-1:0]         best_burst_r, best_burst_nxt;
  logic [TIME_W-1:0]     age_r, age_nxt;
  logic [BW-1:0]         ent_burst_r, ent_burst_nxt;
  logic [IDW-1:0]        ent_id_r, ent_id_nxt;

  logic                  in_fire;
  logic                  is_tick;
  logic                  q_full;
  logic                  busy_after;
  logic                  out_free;
  logic [CW-1:0]         idx_inc;
  logic [CW-1:0]         best_inc;
  logic [BW-1:0]         in_burst;
  logic [BW-1:0]         in_burst_fix;
  logic [IDW-1:0]        in_id;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [BW-1:0]         rd_burst;
  logic [TIME_W-1:0]     rd_stamp;
  logic [IDW-1:0]        rd_id;
  logic                  div_start;
  logic [NUM_W-1:0]      div_num;
  div_rsp_t              div_rsp;
  logic [NUM_W-1:0]      div_quo;
  logic [ID_IN_W-1:0]    rep_id;

  assign in_tready    = (state_r == ST_IDLE);
  assign in_fire      = in_tvalid && in_tready;
  assign is_tick      = (in_tuser == ACT_TICK);
  assign q_full       = (cnt_r == CW'(QUEUE_DEPTH));
  assign busy_after   = busy_r && (time_r != fin_r);
  assign out_free     = !out_tvalid_r || out_tready;
  assign idx_inc      = idx_r + CW'(1);
  assign best_inc     = best_idx_r + CW'(1);
  assign in_id        = in_tdata[IDW-1:0];
  assign in_burst     = in_tdata[ID_IN_W +: BW];
  assign in_burst_fix = (in_burst == '0) ? BW'(1) : in_burst;

  assign rd_burst = ram_rdata[BW-1:0];
  assign rd_stamp = ram_rdata[BW +: TIME_W];
  assign rd_id    = ram_rdata[BW+TIME_W +: IDW];

  assign ram_we    = (in_fire && !is_tick && !q_full) || (state_r == ST_SHIFT_WR);
  assign ram_waddr = (state_r == ST_SHIFT_WR) ? idx_r[AW-1:0] : cnt_r[AW-1:0];
  assign ram_wdata = (state_r == ST_SHIFT_WR) ? ram_rdata : {in_id, time_r, in_burst_fix};
  assign ram_raddr = (state_r == ST_SHIFT_RD) ? idx_inc[AW-1:0] : idx_r[AW-1:0];

  assign div_start = (state_r == ST_DIVGO);
  assign div_num   = NUM_W'(age_r) + NUM_W'(ent_burst_r);
  assign rep_id    = busy_r ? ID_IN_W'(cur_r) : '0;

  hrrn_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hrrn_div #(
    .N_W (NUM_W),
    .D_W (BW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (ent_burst_r),
    .rsp   (div_rsp),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && is_tick) begin
          state_nxt = (!busy_after && (cnt_r != '0)) ? ST_RD : ST_REPORT;
        end
      end
      ST_RD:    state_nxt = ST_LATCH;
      ST_LATCH: state_nxt = ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = (idx_inc < cnt_r) ? ST_RD : ST_PICK;
        end
      end
      ST_PICK:     state_nxt = (best_inc < cnt_r) ? ST_SHIFT_RD : ST_REPORT;
      ST_SHIFT_RD: state_nxt = ST_SHIFT_WR;
      ST_SHIFT_WR: state_nxt = (idx_inc < cnt_r) ? ST_SHIFT_RD : ST_REPORT;
      ST_REPORT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    time_nxt       = time_r;
    busy_nxt       = busy_r;
    cur_nxt        = cur_r;
    fin_nxt        = fin_r;
    cnt_nxt        = cnt_r;
    drop_nxt       = drop_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    idx_nxt        = idx_r;
    best_idx_nxt   = best_idx_r;
    best_q_nxt     = best_q_r;
    best_id_nxt    = best_id_r;
    best_burst_nxt = best_burst_r;
    age_nxt        = age_r;
    ent_burst_nxt  = ent_burst_r;
    ent_id_nxt     = ent_id_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_tick) begin
            busy_nxt = busy_after;
            idx_nxt  = '0;
          end else if (q_full) begin
            drop_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      ST_LATCH: begin
        age_nxt       = time_r - rd_stamp;
        ent_burst_nxt = rd_burst;
        ent_id_nxt    = rd_id;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if ((idx_r == '0) || (div_quo > best_q_r)) begin
            best_q_nxt     = div_quo;
            best_idx_nxt   = idx_r;
            best_id_nxt    = ent_id_r;
            best_burst_nxt = ent_burst_r;
          end
          idx_nxt = idx_inc;
        end
      end
      ST_PICK: begin
        busy_nxt = 1'b1;
        cur_nxt  = best_id_r;
        fin_nxt  = time_r + TIME_W'(best_burst_r);
        cnt_nxt  = cnt_r - CW'(1);
        idx_nxt  = best_idx_r;
      end
      ST_SHIFT_WR: idx_nxt = idx_inc;
      ST_REPORT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{OUT_PAD_W{1'b0}}, drop_r, rep_id, busy_r, time_r};
          drop_nxt       = 1'b0;
          time_nxt       = time_r + TIME_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      time_r       <= '0;
      busy_r       <= 1'b0;
      cur_r        <= '0;
      fin_r        <= '0;
      cnt_r        <= '0;
      drop_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      time_r       <= time_nxt;
      busy_r       <= busy_nxt;
      cur_r        <= cur_nxt;
      fin_r        <= fin_nxt;
      cnt_r        <= cnt_nxt;
      drop_r       <= drop_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r  <= out_tdata_nxt;
    idx_r        <= idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_q_r     <= best_q_nxt;
    best_id_r    <= best_id_nxt;
    best_burst_r <= best_burst_nxt;
    age_r        <= age_nxt;
    ent_burst_r  <= ent_burst_nxt;
    ent_id_r     <= ent_id_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `HRRN_CHK(a_cnt_range, 1'b1, cnt_r <= CW'(QUEUE_DEPTH))
  `HRRN_CHK(a_scan_idx, state_r == ST_RD, idx_r < cnt_r)
  `HRRN_CHK(a_idle_id, out_tvalid_r && !out_tdata_r[TIME_W], out_tdata_r[TIME_W+1 +: ID_IN_W] == '0)
  `HRRN_NEXT(a_report_load, state_r == ST_REPORT && out_free, out_tvalid_r && state_r == ST_IDLE)
  `HRRN_NEXT(a_pick_busy, state_r == ST_PICK, busy_r)

endmodule
